FILE: rtl/core/arq_pkg.sv
`default_nettype none
package arq_pkg;

  typedef enum logic [1:0] {
    REQ_INSERT      = 2'd0,
    REQ_TICK        = 2'd1,
    REQ_REMOVE_RDY  = 2'd2,
    REQ_REMOVE_PEND = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_EMPTY   = 2'd1,
    ERR_INVALID = 2'd2,
    ERR_FULL    = 2'd3
  } err_t;

  localparam int ID_W    = 4;
  localparam int CNT_W   = 5;
  localparam int FTIME_W = 16;

endpackage
`default_nettype wire

FILE: rtl/core/arrival_release_queue.sv
`default_nettype none
// Time-ordered release queue. It holds a pending list, kept stably sorted by
// arrival time, and a ready FIFO, both in synchronous memories with registered
// read data. A request is accepted only while the block is idle, and it gives
// exactly one result word, which is held until it is taken. A rejected request
// has its result word offered in the next cycle. An insert walks the pending
// list from the tail: for each entry examined it reads the entry, fetches its
// key and compares, shifting a later entry up by one place, at most L entries
// for a pending list of length L; then it places the new entry. A remove at
// index i from a list of length L shifts the L-i-1 entries after it down. A
// tick checks each pending head in turn until the list is empty, the head is
// not yet due or the ready FIFO is full; each head that is released moves to
// the ready FIFO and the other L-1 entries of a list of length L shift down.
// Configuration is accepted only while no request is in progress.
module arrival_release_queue #(
  parameter int MAX_PROCS = 16,
  parameter int TIME_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [arq_pkg::CNT_W-1:0]    cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   req_type,
  input  wire logic [arq_pkg::ID_W-1:0]     proc_id,
  input  wire logic [arq_pkg::FTIME_W-1:0]  arrival_time,
  input  wire logic [arq_pkg::FTIME_W-1:0]  time_now,
  input  wire logic [arq_pkg::ID_W-1:0]     position,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [arq_pkg::ID_W-1:0]          removed_id,
  output logic [arq_pkg::CNT_W-1:0]         moved_count,
  output logic [1:0]                        error_code
);

  localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int LW = $clog2(MAX_PROCS + 1);
  localparam int IW = arq_pkg::ID_W;
  localparam logic [LW-1:0] FULL_LEN = LW'(MAX_PROCS);
  localparam logic [31:0] MAX_U = 32'(MAX_PROCS);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_INS_RD  = 12'b000000000010,
    S_INS_KEY = 12'b000000000100,
    S_INS_CMP = 12'b000000001000,
    S_INS_PUT = 12'b000000010000,
    S_TCK_CHK = 12'b000000100000,
    S_TCK_KEY = 12'b000001000000,
    S_TCK_CMP = 12'b000010000000,
    S_REM_GOT = 12'b000100000000,
    S_SH_RD   = 12'b001000000000,
    S_SH_WR   = 12'b010000000000,
    S_OUT     = 12'b100000000000
  } state_t;

  state_t state;
  logic [arq_pkg::CNT_W-1:0] proc_count;
  logic [LW-1:0] pend_len, rdy_len;
  arq_pkg::req_t req_r;
  logic [IW-1:0] id_r;
  logic [TIME_BITS-1:0] t_r;
  logic [LW-1:0] idx;
  logic [IW-1:0] cur_id;
  logic list_rdy;
  logic [IW-1:0] got;
  logic [arq_pkg::CNT_W-1:0] moved;
  arq_pkg::err_t err_r;

  logic p_we, r_we, a_we;
  logic [AW-1:0] p_wa, p_ra, r_wa, r_ra, a_wa, a_ra;
  logic [IW-1:0] p_wd, p_rd, r_wd, r_rd;
  logic [TIME_BITS-1:0] a_wd, a_rd;

  arq_mem #(.DEPTH(MAX_PROCS), .WIDTH(IW)) u_pend (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
  arq_mem #(.DEPTH(MAX_PROCS), .WIDTH(IW)) u_rdy (
    .clk, .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd));
  arq_mem #(.DEPTH(MAX_PROCS), .WIDTH(TIME_BITS)) u_arr (
    .clk, .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));

  assign cfg_ready   = (state == S_IDLE);
  assign in_stall    = (state != S_IDLE);
  assign out_valid   = (state == S_OUT);
  assign removed_id  = got;
  assign moved_count = moved;
  assign error_code  = err_r;

  logic [LW-1:0] len_in, len_sel;
  logic [31:0] id32, pos32, len32;
  logic [IW-1:0] sh_data;
  logic tck_move;
  arq_pkg::err_t ins_err, rem_err;

  assign len_in   = (req_type == arq_pkg::REQ_REMOVE_RDY) ? rdy_len : pend_len;
  assign len_sel  = list_rdy ? rdy_len : pend_len;
  assign id32     = 32'(proc_id);
  assign pos32    = 32'(position);
  assign len32    = 32'(len_in);
  assign sh_data  = list_rdy ? r_rd : p_rd;
  assign tck_move = (a_rd <= t_r) && (rdy_len != FULL_LEN);

  always_comb begin
    ins_err = arq_pkg::ERR_OK;
    if (({1'b0, proc_id} >= proc_count) || (id32 >= MAX_U)) begin
      ins_err = arq_pkg::ERR_INVALID;
    end else if (pend_len == FULL_LEN) begin
      ins_err = arq_pkg::ERR_FULL;
    end
  end

  always_comb begin
    rem_err = arq_pkg::ERR_OK;
    if (proc_count == '0) begin
      rem_err = arq_pkg::ERR_EMPTY;
    end else if ({1'b0, position} >= proc_count) begin
      rem_err = arq_pkg::ERR_INVALID;
    end else if (len_in == '0) begin
      rem_err = arq_pkg::ERR_EMPTY;
    end else if ((pos32 >= len32) || (pos32 >= MAX_U)) begin
      rem_err = arq_pkg::ERR_INVALID;
    end
  end

  always_comb begin
    p_we = 1'b0;
    r_we = 1'b0;
    a_we = 1'b0;
    p_wa = AW'(idx);
    p_wd = cur_id;
    r_wa = AW'(idx);
    r_wd = sh_data;
    a_wa = AW'(proc_id);
    a_wd = TIME_BITS'(arrival_time);
    p_ra = '0;
    r_ra = '0;
    a_ra = AW'(p_rd);
    case (state)
      S_IDLE: begin
        p_ra = AW'(position);
        r_ra = AW'(position);
        a_we = in_valid && (req_type == arq_pkg::REQ_INSERT) && (ins_err == arq_pkg::ERR_OK);
      end
      S_INS_RD: p_ra = AW'(idx - LW'(1));
      S_INS_CMP: p_we = (a_rd > t_r);
      S_INS_PUT: begin
        p_we = 1'b1;
        p_wd = id_r;
      end
      S_TCK_CMP: begin
        r_we = tck_move;
        r_wa = AW'(rdy_len);
        r_wd = cur_id;
      end
      S_SH_RD: begin
        p_ra = AW'(idx + LW'(1));
        r_ra = AW'(idx + LW'(1));
      end
      S_SH_WR: begin
        p_we = !list_rdy;
        r_we = list_rdy;
        p_wd = sh_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      proc_count <= 5'd16;
      pend_len <= '0;
      rdy_len <= '0;
      req_r <= arq_pkg::REQ_INSERT;
      id_r <= '0;
      t_r <= '0;
      idx <= '0;
      cur_id <= '0;
      list_rdy <= 1'b0;
      got <= '0;
      moved <= '0;
      err_r <= arq_pkg::ERR_OK;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_valid) proc_count <= cfg_data;
          if (in_valid) begin
            req_r <= arq_pkg::req_t'(req_type);
            id_r <= proc_id;
            got <= '0;
            moved <= '0;
            err_r <= arq_pkg::ERR_OK;
            case (arq_pkg::req_t'(req_type))
              arq_pkg::REQ_INSERT: begin
                t_r <= TIME_BITS'(arrival_time);
                idx <= pend_len;
                if (ins_err != arq_pkg::ERR_OK) begin
                  err_r <= ins_err;
                  state <= S_OUT;
                end else if (pend_len == '0) begin
                  state <= S_INS_PUT;
                end else begin
                  state <= S_INS_RD;
                end
              end
              arq_pkg::REQ_TICK: begin
                t_r <= TIME_BITS'(time_now);
                idx <= '0;
                list_rdy <= 1'b0;
                state <= S_TCK_CHK;
              end
              default: begin
                idx <= LW'(position);
                list_rdy <= (req_type == arq_pkg::REQ_REMOVE_RDY);
                if (rem_err != arq_pkg::ERR_OK) begin
                  err_r <= rem_err;
                  state <= S_OUT;
                end else begin
                  state <= S_REM_GOT;
                end
              end
            endcase
          end
        end
        S_INS_RD: state <= S_INS_KEY;
        S_INS_KEY: begin
          cur_id <= p_rd;
          state <= S_INS_CMP;
        end
        S_INS_CMP: begin
          if (a_rd > t_r) begin
            idx <= idx - LW'(1);
            state <= (idx == LW'(1)) ? S_INS_PUT : S_INS_RD;
          end else begin
            state <= S_INS_PUT;
          end
        end
        S_INS_PUT: begin
          pend_len <= pend_len + LW'(1);
          state <= S_OUT;
        end
        S_TCK_CHK: state <= (pend_len == '0) ? S_OUT : S_TCK_KEY;
        S_TCK_KEY: begin
          cur_id <= p_rd;
          state <= S_TCK_CMP;
        end
        S_TCK_CMP: begin
          if (a_rd > t_r) begin
            state <= S_OUT;
          end else if (rdy_len == FULL_LEN) begin
            err_r <= arq_pkg::ERR_FULL;
            state <= S_OUT;
          end else begin
            rdy_len <= rdy_len + LW'(1);
            moved <= moved + 5'd1;
            idx <= '0;
            if (pend_len == LW'(1)) begin
              pend_len <= '0;
              state <= S_TCK_CHK;
            end else begin
              state <= S_SH_RD;
            end
          end
        end
        S_REM_GOT: begin
          got <= sh_data;
          if ((idx + LW'(1)) >= len_sel) begin
            if (list_rdy) rdy_len <= rdy_len - LW'(1);
            else pend_len <= pend_len - LW'(1);
            state <= S_OUT;
          end else begin
            state <= S_SH_RD;
          end
        end
        S_SH_RD: state <= S_SH_WR;
        S_SH_WR: begin
          idx <= idx + LW'(1);
          if ((idx + LW'(2)) >= len_sel) begin
            if (list_rdy) rdy_len <= rdy_len - LW'(1);
            else pend_len <= pend_len - LW'(1);
            state <= (req_r == arq_pkg::REQ_TICK) ? S_TCK_CHK : S_OUT;
          end else begin
            state <= S_SH_RD;
          end
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(removed_id) &&
                                  $stable(moved_count) && $stable(error_code)));
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state));
  a_pend_len: assert property (@(posedge clk) disable iff (rst) pend_len <= FULL_LEN);
  a_rdy_len: assert property (@(posedge clk) disable iff (rst) rdy_len <= FULL_LEN);
  a_busy: assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall);

endmodule
`default_nettype wire

FILE: rtl/core/arq_mem.sv
`default_nettype none
module arq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
